### hw/rtl/ptim_pkg.sv
// Shared types and constants for the page table identity mapper.
package ptim_pkg;

    localparam logic [63:0] AddrMask = 64'h000F_FFFF_FFFF_F000;
    localparam logic [63:0] MmioBits = 64'h7B;   // P RW PWT PCD A D
    localparam logic [63:0] TblBits  = 64'h3;    // P RW
    localparam logic [63:0] BitPs    = 64'h80;

    localparam logic [1:0] OpMap   = 2'd0;
    localparam logic [1:0] OpRead  = 2'd1;
    localparam logic [1:0] OpWrite = 2'd2;

    localparam logic [2:0] StOk      = 3'd0;
    localparam logic [2:0] StBadArgs = 3'd1;

    localparam logic [3:0] RegPoolBase = 4'd0;   // byte address 0
    localparam logic [3:0] RegFive     = 4'd8;   // byte address 8

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_EREAD, S_EWAIT, S_PAGE, S_RD, S_RWAIT, S_DEC,
        S_ZERO, S_SPLIT, S_LINK, S_LEAF, S_NEXT, S_DONE
    } t_state;

endpackage

### hw/rtl/page_table_identity_mapper.sv
// Top level: page table walker with its sequencer and table store.
//
// Usage: items enter on the s_axis channel (tdata: op, phys_addr, byte_count,
// entry_page, entry_index, entry_value from bit 0 up). One result per item
// leaves on m_axis (tdata: status, read_value, fail_address). The APB port
// writes pool_base_frame (addr 0) and five_level_enable (addr 8).
// After reset a clearing pass sweeps the whole table store, one entry a cycle,
// 512 entries per page over all pages (page count rounded up to a power of
// two), while o_s_axis_tready stays low.
// An entry read or write passes through S_EREAD and S_EWAIT before its result
// shows. A map item takes each page through S_PAGE, then S_RD, S_RWAIT and
// S_DEC for each level walked, then S_LEAF and S_NEXT; each newly taken table
// is first zeroed or split in all 512 entries and then linked, all through the
// one memory port. One item is worked at a time; the result is held in an
// output register until taken, and the next item is accepted only then.
module page_table_identity_mapper
    import ptim_pkg::*;
#(
    parameter int POOL_PAGES = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // op[1:0] phys_addr[53:2] byte_count[93:54] entry_page[99:94]
    // entry_index[108:100] entry_value[172:109], zero fill to 176
    input  logic [175:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // status[2:0] read_value[66:3] fail_address[118:67], zero fill to 120
    output logic [119:0] o_m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);
    localparam int PW = $clog2(POOL_PAGES);
    localparam int AW = PW + 9;
    localparam int CW = PW + 1;

    t_state r_state, n_state;
    logic [39:0] r_base;
    logic        r_five;
    logic [1:0]  r_op;
    logic [63:0] r_cur, r_end, r_val;
    logic [5:0]  r_epage;
    logic [8:0]  r_eidx;
    logic [PW-1:0] r_tbl, r_newpg;
    logic [2:0]  r_lv;
    logic [CW-1:0] r_free;
    logic [AW:0] r_cnt;
    logic [63:0] r_desc;
    logic [2:0]  r_st;
    logic [63:0] r_rv;
    logic [51:0] r_fa;
    logic        r_ovalid;

    logic        w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [63:0] w_wdata, w_rdata;

    ptim_mem #(.AW(AW)) u_mem (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    // entry page as a pool index, and whether it lies inside the pool
    logic [PW-1:0] w_epg;
    logic          w_epin;
    assign w_epg  = PW'(r_epage);
    assign w_epin = int'(r_epage) < POOL_PAGES;

    // index of current level: lv 0 PML5 .. 3 PD
    logic [8:0]  w_idx;
    logic [39:0] w_off;
    logic        w_inpool, w_pres, w_ps, w_pool_full;
    logic [63:0] w_huge, w_base, w_attrs, w_child;
    logic [8:0]  w_i;
    always_comb begin
        unique case (r_lv[1:0])
            2'd0:    w_idx = r_cur[56:48];
            2'd1:    w_idx = r_cur[47:39];
            2'd2:    w_idx = r_cur[38:30];
            default: w_idx = r_cur[29:21];
        endcase
        w_off = r_desc[51:12] - r_base;
        w_inpool = w_off < 40'(POOL_PAGES);
        w_pres = r_desc[0];
        w_ps = r_desc[7];
        w_pool_full = r_free >= CW'(POOL_PAGES);
        w_huge = (r_lv == 3'd2) ? 64'h4000_0000 : 64'h20_0000;
        w_base = (r_desc & AddrMask) & ~(w_huge - 64'd1);
        w_attrs = r_desc & ~AddrMask;
        if (r_lv == 3'd3) w_attrs = w_attrs & ~BitPs;
        w_i = r_cnt[8:0];
        w_child = (r_lv == 3'd2) ? {w_base[63:30], w_i, 21'd0} : {w_base[63:21], w_i, 12'd0};
    end

    logic [39:0] w_pfr;
    assign w_pfr = r_base + 40'(r_newpg);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_cnt == (AW+1)'(2**AW - 1)) n_state = S_IDLE;
            S_IDLE: if (i_s_axis_tvalid) begin
                if (i_s_axis_tdata[1:0] == OpMap) begin
                    if (i_s_axis_tdata[53:2] == 52'd0 || i_s_axis_tdata[93:54] == 40'd0)
                        n_state = S_DONE;
                    else n_state = S_PAGE;
                end else if (i_s_axis_tdata[1:0] == OpRead ||
                             i_s_axis_tdata[1:0] == OpWrite) begin
                    n_state = S_EREAD;
                end else n_state = S_DONE;
            end
            S_EREAD: n_state = S_EWAIT;
            S_EWAIT: n_state = S_DONE;
            S_PAGE:  n_state = (r_cur < r_end) ? S_RD : S_DONE;
            S_RD:    n_state = S_RWAIT;
            S_RWAIT: n_state = S_DEC;
            S_DEC: begin
                if (w_pres && !w_ps) n_state = w_inpool ? ((r_lv == 3'd3) ? S_LEAF : S_RD)
                                                         : S_DONE;
                else if (w_pres && (r_lv < 3'd2)) n_state = S_DONE;
                else if (w_pool_full) n_state = S_DONE;
                else n_state = w_pres ? S_SPLIT : S_ZERO;
            end
            S_ZERO, S_SPLIT: if (r_cnt[8:0] == 9'h1FF) n_state = S_LINK;
            S_LINK:  n_state = (r_lv == 3'd3) ? S_LEAF : S_RD;
            S_LEAF:  n_state = S_NEXT;
            S_NEXT:  n_state = S_PAGE;
            S_DONE:  if (i_m_axis_tready || !r_ovalid) n_state = r_ovalid ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // memory port
    always_comb begin
        w_we = 1'b0;
        w_waddr = '0;
        w_wdata = '0;
        w_raddr = {r_tbl, w_idx};
        unique case (r_state)
            S_CLEAR: begin w_we = 1'b1; w_waddr = r_cnt[AW-1:0]; end
            S_EREAD: begin
                w_raddr = {w_epg, r_eidx};
                w_we = (r_op == OpWrite) && w_epin;
                w_waddr = {w_epg, r_eidx};
                w_wdata = r_val;
            end
            S_ZERO:  begin w_we = 1'b1; w_waddr = {r_newpg, w_i}; end
            S_SPLIT: begin
                w_we = 1'b1; w_waddr = {r_newpg, w_i};
                w_wdata = (w_child & AddrMask) | w_attrs;
            end
            S_LINK: begin
                w_we = 1'b1; w_waddr = {r_tbl, w_idx};
                w_wdata = ({12'd0, w_pfr, 12'd0} & AddrMask) | TblBits;
            end
            S_LEAF: begin
                w_we = 1'b1; w_waddr = {r_tbl, r_cur[20:12]};
                w_wdata = (r_cur & AddrMask) | MmioBits;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt <= '0;
            r_free <= CW'(1);
            r_base <= '0;
            r_five <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (psel && penable && pwrite) begin
                if (paddr == RegPoolBase) r_base <= pwdata[39:0];
                else if (paddr == RegFive) r_five <= pwdata[0];
            end
            unique case (r_state)
                S_CLEAR: r_cnt <= r_cnt + 1'b1;
                S_IDLE: begin
                    r_op <= i_s_axis_tdata[1:0];
                    r_cur <= {12'd0, i_s_axis_tdata[53:14], 12'd0};
                    r_end <= (64'(i_s_axis_tdata[53:2]) + 64'(i_s_axis_tdata[93:54])
                              + 64'hFFF) & ~64'hFFF;
                    r_epage <= i_s_axis_tdata[99:94];
                    r_eidx <= i_s_axis_tdata[108:100];
                    r_val <= i_s_axis_tdata[172:109];
                    r_st <= (i_s_axis_tdata[1:0] == OpMap) ? StBadArgs : StOk;
                    r_rv <= '0;
                    r_fa <= '0;
                end
                S_EWAIT: if (r_op == OpRead && w_epin) r_rv <= w_rdata;
                S_PAGE: begin
                    r_st <= StOk;
                    r_tbl <= '0;
                    r_lv <= r_five ? 3'd0 : 3'd1;
                end
                S_RWAIT: r_desc <= w_rdata;
                S_DEC: begin
                    r_cnt <= '0;
                    r_newpg <= r_free[PW-1:0];
                    if (w_pres && !w_ps) begin
                        if (w_inpool) begin
                            r_tbl <= w_off[PW-1:0];
                            if (r_lv != 3'd3) r_lv <= r_lv + 1'b1;
                        end
                    end else if (!(w_pres && r_lv < 3'd2) && !w_pool_full) begin
                        r_free <= r_free + 1'b1;
                    end
                    if (n_state == S_DONE) begin
                        r_st <= r_lv + 3'd2;
                        r_fa <= r_cur[51:0];
                    end
                end
                S_ZERO, S_SPLIT: r_cnt <= r_cnt + 1'b1;
                S_LINK: begin
                    r_tbl <= r_newpg;
                    if (r_lv != 3'd3) r_lv <= r_lv + 1'b1;
                end
                S_NEXT: r_cur <= r_cur + 64'h1000;
                S_DONE: begin
                    if (!r_ovalid) r_ovalid <= 1'b1;
                    else if (i_m_axis_tready) r_ovalid <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata = {1'b0, r_fa, r_rv, r_st};
    assign pready = 1'b1;
    always_comb begin
        unique case (paddr)
            RegPoolBase: prdata = {24'd0, r_base};
            RegFive:     prdata = {63'd0, r_five};
            default:     prdata = '0;
        endcase
    end

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= CW'(POOL_PAGES) + CW'(1)) else $error("pool pointer overran");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> r_state == S_DONE) else $error("result shown outside done");
    a_no_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> !o_s_axis_tready) else $error("ready during clear");
endmodule

### hw/rtl/ptim_mem.sv
// Table store: single-port-write, registered-read memory.
module ptim_mem
    import ptim_pkg::*;
#(
    parameter int AW = 15
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [63:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [63:0]   o_rdata
);
    logic [63:0] r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
